FILE: sv/tesd_pkg.sv
// shared types and constants of the text escape symbol decoder
// no dependencies; imported by every module of the block but tesd_ram

package tesd_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int QUEUE_DEPTH = 4;
	localparam int CFG_W       = 10;
	localparam int CFG_IDX_W   = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_START_FONT     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FONT_COUNT     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHARS_PER_FONT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SYMBOLS    = 2'd3;

	// result kinds
	localparam logic KIND_SYMBOL = 1'b0;
	localparam logic KIND_END    = 1'b1;

	// input modes
	localparam logic MODE_TABLE = 1'b0;
	localparam logic MODE_TEXT  = 1'b1;

	typedef struct packed {
		logic              mode;
		logic [9:0]        table_address;
		logic signed [15:0] table_word;
		logic [7:0]        text_byte;
		logic              last_byte;
	} in_item_t;

	typedef struct packed {
		logic              kind;
		logic signed [15:0] symbol;
		logic [9:0]        position;
	} out_item_t;

	typedef struct packed {
		logic [2:0] start_font;
		logic [2:0] font_count;
		logic [8:0] chars_per_font;
		logic [9:0] max_symbols;
	} cfg_t;

	// one symbol to emit: table lookup at the command's address or an immediate value
	typedef struct packed {
		logic        valid;
		logic        lookup;
		logic [15:0] value;
		logic [9:0]  pos;
	} slot_t;

	// classified item handed from the front end to the back end
	typedef struct packed {
		logic              is_write;
		logic [ADDR_W-1:0] addr;
		logic [15:0]       wdata;
		slot_t [1:0]       slot;
		logic              end_valid;
		logic [9:0]        end_pos;
	} cmd_t;

endpackage

FILE: sv/tesd_ram.sv
// generic single-port-write, single-port-read RAM with registered read data
// no dependencies

module tesd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/tesd_front.sv
// front end: accepts items, runs the escape parser and classifies each item
// into a command for the back end; depends on tesd_pkg

module tesd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  tesd_pkg::in_item_t in_item,
	input  tesd_pkg::cfg_t    cfg,
	input  logic              full,
	output logic              push,
	output tesd_pkg::cmd_t    cmd
);

	import tesd_pkg::*;

	typedef enum logic [2:0] {
		PH_NORMAL,
		PH_ESCAPE,
		PH_FONT,
		PH_GREEK,
		PH_NUMBER
	} phase_t;

	localparam logic [7:0] CHAR_SPACE  = 8'h20;
	localparam logic [7:0] CHAR_HASH   = 8'h23;
	localparam logic [7:0] CHAR_LPAREN = 8'h28;
	localparam logic [7:0] CHAR_RPAREN = 8'h29;
	localparam logic [7:0] CHAR_PLUS   = 8'h2B;
	localparam logic [7:0] CHAR_MINUS  = 8'h2D;
	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_NINE   = 8'h39;
	localparam logic [7:0] CHAR_B_UP   = 8'h42;
	localparam logic [7:0] CHAR_D_UP   = 8'h44;
	localparam logic [7:0] CHAR_F_UP   = 8'h46;
	localparam logic [7:0] CHAR_G_UP   = 8'h47;
	localparam logic [7:0] CHAR_U_UP   = 8'h55;
	localparam logic [7:0] CHAR_B_LO   = 8'h62;
	localparam logic [7:0] CHAR_D_LO   = 8'h64;
	localparam logic [7:0] CHAR_F_LO   = 8'h66;
	localparam logic [7:0] CHAR_G_LO   = 8'h67;
	localparam logic [7:0] CHAR_I_LO   = 8'h69;
	localparam logic [7:0] CHAR_N_LO   = 8'h6E;
	localparam logic [7:0] CHAR_R_LO   = 8'h72;
	localparam logic [7:0] CHAR_S_LO   = 8'h73;
	localparam logic [7:0] CHAR_U_LO   = 8'h75;
	localparam logic [7:0] GREEK_BASE  = 8'd127;

	localparam logic [15:0] SYM_UP    = 16'hFFFF;
	localparam logic [15:0] SYM_DOWN  = 16'hFFFE;
	localparam logic [15:0] SYM_BACK  = 16'hFFFD;
	localparam logic [15:0] SYM_PLUS  = 16'hFFFC;
	localparam logic [15:0] SYM_MINUS = 16'hFFFB;

	// position of a greek letter in the greek list, from 1; 0 if none
	function automatic logic [5:0] greek_pos(input logic [7:0] b);
		logic [5:0] p;
		p = 6'd0;
		unique case (b | 8'h20)
			8'h61: p = 6'd1;
			8'h62: p = 6'd2;
			8'h67: p = 6'd3;
			8'h64: p = 6'd4;
			8'h65: p = 6'd5;
			8'h7A: p = 6'd6;
			8'h79: p = 6'd7;
			8'h68: p = 6'd8;
			8'h69: p = 6'd9;
			8'h6B: p = 6'd10;
			8'h6C: p = 6'd11;
			8'h6D: p = 6'd12;
			8'h6E: p = 6'd13;
			8'h63: p = 6'd14;
			8'h6F: p = 6'd15;
			8'h70: p = 6'd16;
			8'h72: p = 6'd17;
			8'h73: p = 6'd18;
			8'h74: p = 6'd19;
			8'h75: p = 6'd20;
			8'h66: p = 6'd21;
			8'h78: p = 6'd22;
			8'h71: p = 6'd23;
			8'h77: p = 6'd24;
			default: p = 6'd0;
		endcase
		// lower case letters follow the upper case ones
		if (p != 6'd0 && b[5]) begin
			p = p + 6'd24;
		end
		return p;
	endfunction

	function automatic logic [2:0] font_sel(input logic [7:0] b, input logic [2:0] count);
		logic [2:0] f;
		f = 3'd0;
		unique case (b | 8'h20)
			CHAR_N_LO: f = 3'd1;
			CHAR_R_LO: f = 3'd2;
			CHAR_I_LO: f = 3'd3;
			CHAR_S_LO: f = 3'd4;
			default:   f = 3'd0;
		endcase
		if (f == 3'd0 || f > count) begin
			f = 3'd1;
		end
		return f;
	endfunction

	phase_t      phase_q;
	logic [2:0]  font_q;
	logic [15:0] acc_q;
	logic [9:0]  cnt_q;
	logic        in_string_q;

	logic        accept;
	logic [7:0]  b;
	logic        last;
	logic [2:0]  init_font;
	phase_t      cur_phase;
	logic [2:0]  cur_font;
	logic [15:0] cur_acc;
	logic [9:0]  cur_cnt;

	phase_t      nxt_phase;
	logic [2:0]  nxt_font;
	logic [15:0] nxt_acc;
	logic        a_req;
	logic        a_lookup;
	logic [15:0] a_val;
	logic        b_req;
	logic [7:0]  idx;
	logic        plain_hash;
	logic [7:0]  plain_idx;
	logic        is_digit;
	logic [15:0] acc10;

	logic        a_emit;
	logic        b_emit;
	logic [9:0]  cnt_a;
	logic [9:0]  cnt_b;
	logic [1:0]  font_m1;
	logic [10:0] prod;
	logic [11:0] sum;

	assign accept = in_valid && !full;
	assign push   = accept;
	assign b      = in_item.text_byte;
	assign last   = in_item.last_byte;

	assign init_font = (cfg.start_font == 3'd0 || cfg.start_font > cfg.font_count)
		? 3'd1 : cfg.start_font;

	// a new string starts from a clean parser
	assign cur_phase = in_string_q ? phase_q : PH_NORMAL;
	assign cur_font  = in_string_q ? font_q : init_font;
	assign cur_acc   = in_string_q ? acc_q : 16'd0;
	assign cur_cnt   = in_string_q ? cnt_q : 10'd0;

	assign plain_hash = (b == CHAR_HASH) && !last;
	assign plain_idx  = b[7] ? CHAR_SPACE : b;
	assign is_digit   = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
	assign acc10      = 16'({cur_acc, 3'b000}) + 16'({cur_acc, 1'b0}) + 16'(b[3:0]);

	always_comb begin
		nxt_phase = PH_NORMAL;
		nxt_font  = cur_font;
		nxt_acc   = cur_acc;
		a_req     = 1'b0;
		a_lookup  = 1'b0;
		a_val     = 16'd0;
		b_req     = 1'b0;
		idx       = plain_idx;
		unique case (cur_phase)
			PH_ESCAPE: begin
				unique case (b) inside
					CHAR_HASH: begin
						a_req    = 1'b1;
						a_lookup = 1'b1;
						idx      = CHAR_HASH;
					end
					CHAR_U_LO, CHAR_U_UP: begin
						a_req = 1'b1;
						a_val = SYM_UP;
					end
					CHAR_D_LO, CHAR_D_UP: begin
						a_req = 1'b1;
						a_val = SYM_DOWN;
					end
					CHAR_B_LO, CHAR_B_UP: begin
						a_req = 1'b1;
						a_val = SYM_BACK;
					end
					CHAR_PLUS: begin
						a_req = 1'b1;
						a_val = SYM_PLUS;
					end
					CHAR_MINUS: begin
						a_req = 1'b1;
						a_val = SYM_MINUS;
					end
					CHAR_LPAREN: begin
						nxt_acc = 16'd0;
						if (last) begin
							a_req = 1'b1;
						end else begin
							nxt_phase = PH_NUMBER;
						end
					end
					CHAR_F_LO, CHAR_F_UP: begin
						if (!last) begin
							nxt_phase = PH_FONT;
						end
					end
					CHAR_G_LO, CHAR_G_UP: begin
						if (!last) begin
							nxt_phase = PH_GREEK;
						end
					end
					default: begin
						// unknown pair is dropped
					end
				endcase
			end
			PH_FONT: begin
				nxt_font = font_sel(b, cfg.font_count);
			end
			PH_GREEK: begin
				a_req    = 1'b1;
				a_lookup = 1'b1;
				idx      = GREEK_BASE + 8'(greek_pos(b));
			end
			PH_NUMBER: begin
				if (is_digit) begin
					nxt_acc   = acc10;
					nxt_phase = PH_NUMBER;
					if (last) begin
						a_req = 1'b1;
						a_val = acc10;
					end
				end else begin
					a_req = 1'b1;
					a_val = cur_acc;
					// the terminating byte is decoded as plain text unless it closes the number
					if (b != CHAR_RPAREN) begin
						if (plain_hash) begin
							nxt_phase = PH_ESCAPE;
						end else begin
							b_req = 1'b1;
						end
					end
				end
			end
			default: begin
				if (plain_hash) begin
					nxt_phase = PH_ESCAPE;
				end else begin
					a_req    = 1'b1;
					a_lookup = 1'b1;
				end
			end
		endcase
	end

	// symbol limit
	assign a_emit = a_req && (cur_cnt < cfg.max_symbols);
	assign cnt_a  = cur_cnt + 10'(a_emit);
	assign b_emit = b_req && (cnt_a < cfg.max_symbols);
	assign cnt_b  = cnt_a + 10'(b_emit);

	// table address; at most one lookup per item
	assign font_m1 = 2'(cur_font - 3'd1);
	assign prod    = 11'(font_m1 * cfg.chars_per_font);
	assign sum     = 12'(prod) + 12'(idx);

	always_comb begin
		cmd = '0;
		if (in_item.mode == MODE_TABLE) begin
			cmd.is_write = 1'b1;
			cmd.addr     = ADDR_W'(in_item.table_address);
			cmd.wdata    = in_item.table_word;
		end else begin
			cmd.addr           = ADDR_W'(sum);
			cmd.slot[0].valid  = a_emit;
			cmd.slot[0].lookup = a_lookup;
			cmd.slot[0].value  = a_val;
			cmd.slot[0].pos    = cur_cnt;
			cmd.slot[1].valid  = b_emit;
			cmd.slot[1].lookup = 1'b1;
			cmd.slot[1].value  = 16'd0;
			cmd.slot[1].pos    = cnt_a;
			cmd.end_valid      = last;
			cmd.end_pos        = cnt_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_NORMAL;
			font_q      <= 3'd1;
			acc_q       <= 16'd0;
			cnt_q       <= 10'd0;
			in_string_q <= 1'b0;
		end else if (accept && in_item.mode == MODE_TEXT) begin
			if (last) begin
				phase_q     <= PH_NORMAL;
				font_q      <= init_font;
				acc_q       <= 16'd0;
				cnt_q       <= 10'd0;
				in_string_q <= 1'b0;
			end else begin
				phase_q     <= nxt_phase;
				font_q      <= nxt_font;
				acc_q       <= nxt_acc;
				cnt_q       <= cnt_b;
				in_string_q <= 1'b1;
			end
		end
	end

endmodule

FILE: sv/tesd_queue.sv
// short command queue between front end and back end
// depends on tesd_pkg

module tesd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tesd_pkg::cmd_t cmd_in,
	input  logic           pop,
	output logic           full,
	output logic           nonempty,
	output tesd_pkg::cmd_t head
);

	import tesd_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = PTR_W + 1;

	cmd_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign nonempty = (count_q != '0);
	assign head     = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

FILE: sv/tesd_back.sv
// back end: executes queued commands through the lookup table RAM and an output register,
// one table access or result per cycle unless the output stalls; depends on tesd_pkg, tesd_ram

module tesd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                nonempty,
	input  tesd_pkg::cmd_t      head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output tesd_pkg::out_item_t out_item
);

	import tesd_pkg::*;

	logic [2:0]        done_q;
	logic [2:0]        pend;
	logic [2:0]        sel;
	logic              issue;
	logic              out_ready;
	logic              s1_free;
	logic              we;
	logic              re;
	logic [15:0]       rdata;

	logic              iss_kind;
	logic              iss_lookup;
	logic [15:0]       iss_value;
	logic [9:0]        iss_pos;

	logic              valid_s1;
	logic              kind_s1;
	logic              lookup_s1;
	logic [15:0]       value_s1;
	logic [9:0]        pos_s1;

	logic              out_valid_q;
	out_item_t         out_item_q;

	assign out_ready = !out_valid_q || !out_stall;
	assign s1_free   = !valid_s1 || out_ready;

	assign pend = {head.end_valid, head.slot[1].valid, head.slot[0].valid} & ~done_q;

	always_comb begin
		sel        = 3'b000;
		iss_kind   = KIND_SYMBOL;
		iss_lookup = 1'b0;
		iss_value  = 16'd0;
		iss_pos    = 10'd0;
		if (pend[0]) begin
			sel        = 3'b001;
			iss_lookup = head.slot[0].lookup;
			iss_value  = head.slot[0].value;
			iss_pos    = head.slot[0].pos;
		end else if (pend[1]) begin
			sel        = 3'b010;
			iss_lookup = head.slot[1].lookup;
			iss_value  = head.slot[1].value;
			iss_pos    = head.slot[1].pos;
		end else if (pend[2]) begin
			sel      = 3'b100;
			iss_kind = KIND_END;
			iss_pos  = head.end_pos;
		end
	end

	// table writes and commands with no result retire at once; other commands retire with their last result
	always_comb begin
		we    = 1'b0;
		issue = 1'b0;
		pop   = 1'b0;
		if (nonempty) begin
			if (head.is_write) begin
				we  = 1'b1;
				pop = 1'b1;
			end else if (pend == 3'b000) begin
				pop = 1'b1;
			end else if (s1_free) begin
				issue = 1'b1;
				pop   = ((pend & ~sel) == 3'b000);
			end
		end
	end

	assign re = issue && iss_lookup;

	tesd_ram #(
		.WIDTH(16),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(head.addr),
		.wdata(head.wdata),
		.re   (re),
		.raddr(head.addr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= 3'b000;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				done_q <= 3'b000;
			end else if (issue) begin
				done_q <= done_q | sel;
			end
			if (s1_free) begin
				valid_s1 <= issue;
			end
			if (out_ready) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && issue) begin
			kind_s1   <= iss_kind;
			lookup_s1 <= iss_lookup;
			value_s1  <= iss_value;
			pos_s1    <= iss_pos;
		end
		if (out_ready && valid_s1) begin
			out_item_q.kind     <= kind_s1;
			out_item_q.symbol   <= $signed(lookup_s1 ? rdata : value_s1);
			out_item_q.position <= pos_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

FILE: sv/text_escape_symbol_decoder_core.sv
// top level of the text escape symbol decoder: configuration registers,
// front end, command queue and back end; depends on tesd_pkg and all tesd_* modules

// Text bytes (mode 1) are turned into glyph symbols through a lookup table that
// is loaded with mode 0 items; every string ends with an end marker carrying the
// symbol count. The front end parses one item per cycle unless the queue is full
// and pushes a command into a four-entry queue; the back end issues one table
// write, table read or result per cycle unless the output stalls. A byte with
// one result sustains one item per cycle, an item with n results (at most
// three) holds the back end until all are issued, and a table write or a byte
// with no result retires at once. The first result passes the queue entry, the
// table read and the output register before it is valid. The table powers up
// undefined, not cleared; the user writes configuration while idle (not enforced).

module text_escape_symbol_decoder_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  tesd_pkg::in_item_t                    in_item,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output tesd_pkg::out_item_t                   out_item,
	input  logic                                  cfg_write,
	input  logic [tesd_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [tesd_pkg::CFG_W-1:0]            cfg_data
);

	import tesd_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd;
	cmd_t head;
	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_nonempty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_font     <= 3'd1;
			cfg_q.font_count     <= 3'd4;
			cfg_q.chars_per_font <= 9'd176;
			cfg_q.max_symbols    <= 10'd300;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_START_FONT:     cfg_q.start_font     <= cfg_data[2:0];
				CFG_FONT_COUNT:     cfg_q.font_count     <= cfg_data[2:0];
				CFG_CHARS_PER_FONT: cfg_q.chars_per_font <= cfg_data[8:0];
				CFG_MAX_SYMBOLS:    cfg_q.max_symbols    <= cfg_data[9:0];
				default: begin
				end
			endcase
		end
	end

	assign in_stall = q_full;

	tesd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_item (in_item),
		.cfg     (cfg_q),
		.full    (q_full),
		.push    (q_push),
		.cmd     (cmd)
	);

	tesd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.cmd_in  (cmd),
		.pop     (q_pop),
		.full    (q_full),
		.nonempty(q_nonempty),
		.head    (head)
	);

	tesd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.nonempty (q_nonempty),
		.head     (head),
		.pop      (q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item)
	);

	// the front end never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_push)
		else $error("command pushed into full queue");

	// the back end only retires commands that are there
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_nonempty)
		else $error("command popped from empty queue");

	// a retiring command leaves the queue one entry short unless refilled
	a_pop_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(q_full && q_pop) |=> !q_full)
		else $error("queue still full after a pop");

endmodule
